[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helper functions of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Field widths of the request and response items
   localparam int IDX_W       = 10;
   localparam int GRANT_W     = 10;
   localparam int FREE_OUT_W  = 11;

   // Free map storage word
   localparam int WORD_W      = 32;
   localparam int WBIT_W      = 5;

   // Request queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Classified operation
   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_REJECT
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [IDX_W-1:0]  index;
   } op_type;

   // Front to queue
   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   // Queue head seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   // Flow control seen by the front
   typedef struct packed {
      logic full;
      logic busy;
   } flow_type;

   // Lowest set bit of a word (0 when none)
   function automatic logic [WBIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
      logic [WBIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = WBIT_W'(i);
         end
      end
      return r;
   endfunction

   // Reset contents of one free map word starting at block number base
   function automatic logic [WORD_W-1:0] init_word(input logic [31:0] base,
                                                   input logic [31:0] rsv,
                                                   input logic [31:0] ent);
      logic [WORD_W-1:0] w;
      logic [31:0]       blk;
      w = '0;
      for (int j = 0; j < WORD_W; j++) begin
         blk  = base + 32'(j);
         w[j] = (blk >= rsv) && (blk < ent);
      end
      return w;
   endfunction

endpackage

[rtl/bba_channels.sv]
// ----------------------------------------------------------------------------
// bba_channels
// Valid/ready channel interfaces for requests, responses and the CSR write.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [bba_pkg::IDX_W-1:0]  index;

   modport source (output valid, func, index, input ready);
   modport sink   (input valid, func, index, output ready);
   modport mon    (input valid, ready, func, index);
endinterface

interface bba_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bba_pkg::GRANT_W-1:0]     granted;
   logic                            ok;
   logic [bba_pkg::FREE_OUT_W-1:0]  free_left;

   modport source (output valid, granted, ok, free_left, input ready);
   modport sink   (input valid, granted, ok, free_left, output ready);
   modport mon    (input valid, ready, granted, ok, free_left);
endinterface

interface bba_csr_if;
   logic valid;
   logic ready;
   logic enable;

   modport source (output valid, enable, input ready);
   modport sink   (input valid, enable, output ready);
   modport mon    (input valid, ready, enable);
endinterface

[rtl/bba_front.sv]
// ----------------------------------------------------------------------------
// bba_front
// Holds the enable register, accepts requests and classifies each item.
// ----------------------------------------------------------------------------
module bba_front #(
   parameter int ENTRIES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   bba_csr_if.sink            csr_chan,
   bba_req_if.sink            req_chan,
   input  bba_pkg::flow_type  flow,
   output bba_pkg::push_type  push
);
   import bba_pkg::*;

   logic enable_ff;
   logic enable_in;
   logic idx_in_range;

   // Take CSR writes at any time
   assign csr_chan.ready = 1'b1;
   assign enable_in      = (csr_chan.valid) ? csr_chan.enable : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // Stall while the queue is full or the free map is being initialized
   assign req_chan.ready = !flow.full && !flow.busy;

   // Classify the item
   assign idx_in_range = (32'(req_chan.index) < 32'(ENTRIES));

   always_comb begin
      push.valid    = req_chan.valid && req_chan.ready;
      push.op.index = req_chan.index;
      if (!enable_ff) begin
         push.op.kind = OP_REJECT;
      end else if (req_chan.func == FUNC_ALLOC) begin
         push.op.kind = OP_ALLOC;
      end else if (idx_in_range) begin
         push.op.kind = OP_FREE;
      end else begin
         push.op.kind = OP_REJECT;
      end
   end

endmodule

[rtl/bba_queue.sv]
// ----------------------------------------------------------------------------
// bba_queue
// Short FIFO of classified operations between the front and the back end.
// ----------------------------------------------------------------------------
module bba_queue (
   input  logic               clock,
   input  logic               reset,
   input  bba_pkg::push_type  push,
   input  logic               pop,
   output bba_pkg::head_type  head,
   output logic               full
);
   import bba_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

[rtl/bba_engine.sv]
// ----------------------------------------------------------------------------
// bba_engine
// Back end: free map memory with a per-word summary, first-fit search,
// release, free count and the response register.
// ----------------------------------------------------------------------------
module bba_engine #(
   parameter int ENTRIES  = 1024,
   parameter int RESERVED = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  bba_pkg::head_type  head,
   output logic               pop,
   output logic               busy,
   bba_rsp_if.source          rsp_chan
);
   import bba_pkg::*;

   localparam int WORDS      = (ENTRIES + WORD_W - 1) / WORD_W;
   localparam int WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int GROUPS     = (WORDS + WORD_W - 1) / WORD_W;
   localparam int GA_W       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SUM_PAD_W  = GROUPS * WORD_W;
   localparam int RSV        = (RESERVED > ENTRIES) ? ENTRIES : RESERVED;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int CNT_RST    = ENTRIES - RSV;
   localparam int LAST_WORD  = WORDS - 1;
   localparam int LAST_GROUP = GROUPS - 1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_ALLOC,
      ST_FREE,
      ST_DONE
   } state_type;

   // Free map memory and its read register
   logic [WORD_W-1:0]      mem [WORDS];
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   mem_we;
   logic [WA_W-1:0]        mem_waddr;
   logic [WA_W-1:0]        mem_raddr;
   logic [WORD_W-1:0]      mem_wdata;

   // Control and result registers
   state_type              state_ff,  state_in;
   logic [WA_W-1:0]        init_ff,   init_in;
   logic [GA_W-1:0]        grp_ff,    grp_in;
   logic [WA_W-1:0]        word_ff,   word_in;
   logic [WBIT_W-1:0]      fbit_ff,   fbit_in;
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic [WORDS-1:0]       sum_ff,    sum_in;
   logic [GRANT_W-1:0]     res_granted_ff, res_granted_in;
   logic                   res_ok_ff,      res_ok_in;
   logic                   rsp_valid_ff,   rsp_valid_in;
   logic [GRANT_W-1:0]     rsp_granted_ff, rsp_granted_in;
   logic                   rsp_ok_ff,      rsp_ok_in;
   logic [FREE_OUT_W-1:0]  rsp_free_ff,    rsp_free_in;

   // Search helpers
   logic [SUM_PAD_W-1:0]   sum_pad;
   logic [WORD_W-1:0]      sum_slice;
   logic [31:0]            found_word32;
   logic [WBIT_W-1:0]      alloc_bit;
   logic [31:0]            blk32;
   logic [31:0]            free_word32;
   logic [31:0]            count32;

   assign sum_pad      = SUM_PAD_W'(sum_ff);
   assign sum_slice    = sum_pad[32'(grp_ff) * WORD_W +: WORD_W];
   assign found_word32 = 32'(grp_ff) * WORD_W + 32'(first_one(sum_slice));
   assign alloc_bit    = first_one(rd_data_ff);
   assign blk32        = 32'(word_ff) * WORD_W + 32'(alloc_bit);
   assign free_word32  = 32'(head.op.index) >> WBIT_W;
   assign count32      = 32'(count_ff);

   assign busy = (state_ff == ST_INIT);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.granted   = rsp_granted_ff;
   assign rsp_chan.ok        = rsp_ok_ff;
   assign rsp_chan.free_left = rsp_free_ff;

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      grp_in         = grp_ff;
      word_in        = word_ff;
      fbit_in        = fbit_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      res_granted_in = res_granted_ff;
      res_ok_in      = res_ok_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      pop            = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = word_ff;
      mem_wdata      = rd_data_ff;
      mem_raddr      = word_ff;

      case (state_ff)
         // Sweep the reset image into the free map, one word a cycle
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_ff;
            mem_wdata = init_word(32'(init_ff) * WORD_W, 32'(RSV), 32'(ENTRIES));
            init_in   = init_ff + WA_W'(1);
            if (init_ff == WA_W'(LAST_WORD)) begin
               state_in = ST_IDLE;
            end
         end

         // Take the next operation from the queue
         ST_IDLE: begin
            mem_raddr = free_word32[WA_W-1:0];
            if (head.valid) begin
               pop            = 1'b1;
               res_granted_in = '0;
               res_ok_in      = 1'b0;
               case (head.op.kind)
                  OP_ALLOC: begin
                     grp_in   = '0;
                     state_in = (count_ff == '0) ? ST_DONE : ST_SEARCH;
                  end
                  OP_FREE: begin
                     word_in  = free_word32[WA_W-1:0];
                     fbit_in  = head.op.index[WBIT_W-1:0];
                     state_in = ST_FREE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Scan the summary one group of words a cycle
         ST_SEARCH: begin
            mem_raddr = found_word32[WA_W-1:0];
            if (sum_slice != '0) begin
               word_in  = found_word32[WA_W-1:0];
               state_in = ST_ALLOC;
            end else if (grp_ff == GA_W'(LAST_GROUP)) begin
               state_in = ST_DONE;
            end else begin
               grp_in = grp_ff + GA_W'(1);
            end
         end

         // Claim the lowest free bit of the word just read
         ST_ALLOC: begin
            if (rd_data_ff != '0) begin
               mem_we             = 1'b1;
               mem_wdata          = rd_data_ff & ~(WORD_W'(1) << alloc_bit);
               count_in           = count_ff - CNT_W'(1);
               res_granted_in     = blk32[GRANT_W-1:0];
               res_ok_in          = 1'b1;
            end
            state_in = ST_DONE;
         end

         // Release the block if it is in use
         ST_FREE: begin
            if (!rd_data_ff[fbit_ff]) begin
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff | (WORD_W'(1) << fbit_ff);
               count_in  = count_ff + CNT_W'(1);
               res_ok_in = 1'b1;
            end
            state_in = ST_DONE;
         end

         // Hand the result to the response register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_ok_in      = res_ok_ff;
               rsp_free_in    = count32[FREE_OUT_W-1:0];
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Keep the per-word summary in step with every write
      if (mem_we) begin
         sum_in[mem_waddr] = |mem_wdata;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         count_ff     <= CNT_W'(CNT_RST);
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grp_ff         <= grp_in;
      word_ff        <= word_in;
      fbit_ff        <= fbit_in;
      res_granted_ff <= res_granted_in;
      res_ok_ff      <= res_ok_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_free_ff    <= rsp_free_in;
   end

   // Free map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

endmodule

[rtl/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit bitmap allocator: allocate the lowest free block or free a block.
//
//   channel    port      direction  payload
//   request    req_chan  in         func, index
//   response   rsp_chan  out        granted, ok, free_left
//   csr write  csr_chan  in         enable
//
// Allocate steps through search, where the summary is scanned one group at a
// time (one group covers 32 words of 32 blocks, so there is one group for up to
// 1024 blocks), then through alloc and done. Free steps through free and done;
// a rejected request or an allocate from an empty pool goes straight to done.
// The free map read is registered, so the word is read ahead of alloc or free.
// After reset an initialization pass writes the free map, one word a cycle,
// while req_chan.ready stays low.
// A two-entry request queue keeps taking items, until it is full, while the
// engine works or a response waits on rsp_chan.ready.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
   parameter int ENTRIES  = 1024,
   parameter int RESERVED = 10
) (
   input  logic       clock,
   input  logic       reset,
   bba_req_if.sink    req_chan,
   bba_rsp_if.source  rsp_chan,
   bba_csr_if.sink    csr_chan
);
   import bba_pkg::*;

   push_type  push;
   head_type  head;
   flow_type  flow;
   logic      pop;
   logic      q_full;
   logic      eng_busy;

   assign flow.full = q_full;
   assign flow.busy = eng_busy;

   // Accept and classify
   bba_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .flow     (flow),
      .push     (push)
   );

   // Decouple front and back
   bba_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   // Execute against the free map
   bba_engine #(
      .ENTRIES  (ENTRIES),
      .RESERVED (RESERVED)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .busy     (eng_busy),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/bba_checker.sv]
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator response channel, bound to the top.
// ----------------------------------------------------------------------------
module bba_checker #(
   parameter int ENTRIES = 1024
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [bba_pkg::GRANT_W-1:0]      rsp_granted,
   input logic                             rsp_ok,
   input logic [bba_pkg::FREE_OUT_W-1:0]   rsp_free_left
);

   // No response is pending right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A nonzero block number only comes with success
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_granted != '0) |-> rsp_ok)
      else $error("nonzero granted without ok");

   // The free count never exceeds the pool
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_free_left) <= 32'(ENTRIES)))
      else $error("free_left above pool size");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_granted) && $stable(rsp_ok)
         && $stable(rsp_free_left))
      else $error("stalled response changed");

endmodule

bind bitmap_block_allocator bba_checker #(
   .ENTRIES (ENTRIES)
) u_bba_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_granted   (rsp_chan.granted),
   .rsp_ok        (rsp_chan.ok),
   .rsp_free_left (rsp_chan.free_left)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit bitmap block allocator. A shadow
// copy of the free map, free count and enable bit predicts each response.
// Directed tests cover first fit, release, double free, reserved blocks
// and the disabled state. Random traffic with random idling on both
// channels follows.
// ----------------------------------------------------------------------------
module tb_top;
   import bba_pkg::*;

   localparam int BLOCKS          = 1024;
   localparam int RESERVED_BLOCKS = 10;
   localparam int IDLE_PCT        = 21;
   localparam int QUIET_ITEMS     = 60;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 2000;

   localparam logic ALLOC_ON  = 1'b1;
   localparam logic ALLOC_OFF = 1'b0;

   typedef struct packed {
      logic [GRANT_W-1:0]    granted;
      logic                  ok;
      logic [FREE_OUT_W-1:0] free_left;
   } alloc_outcome_type;

   logic clock;
   logic reset;

   bba_req_if req_if ();
   bba_rsp_if rsp_if ();
   bba_csr_if csr_if ();

   bitmap_block_allocator #(
      .ENTRIES  (BLOCKS),
      .RESERVED (RESERVED_BLOCKS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Shadow allocator state
   logic                  pool_free [BLOCKS];
   logic [FREE_OUT_W-1:0] pool_count;
   logic                  alloc_on;

   alloc_outcome_type pending_outcomes [$];
   int                errors;
   int                idle_cycles;
   int                req_gap_pct;
   int                rsp_stall_pct;

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Apply one request to the shadow state and return its outcome
   function automatic alloc_outcome_type serve_request(input logic fn,
                                                       input logic [IDX_W-1:0] idx);
      alloc_outcome_type o;
      int                b;
      logic              found;
      o     = '0;
      found = 1'b0;
      if (alloc_on) begin
         if (fn == FUNC_ALLOC) begin
            for (b = 0; b < BLOCKS; b++) begin
               if (!found && pool_free[b]) begin
                  found        = 1'b1;
                  pool_free[b] = 1'b0;
                  pool_count   = pool_count - 1'b1;
                  o.granted    = GRANT_W'(b);
                  o.ok         = 1'b1;
               end
            end
         end else if (int'(idx) < BLOCKS && !pool_free[idx]) begin
            pool_free[idx] = 1'b1;
            pool_count     = pool_count + 1'b1;
            o.ok           = 1'b1;
         end
      end
      o.free_left = pool_count;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Pick a block to release: mostly used blocks, some from the reserved range and just above it, some random ones
   function automatic logic [IDX_W-1:0] pick_block();
      int start;
      int k;
      int r;
      int sel;
      r     = $urandom_range(99);
      start = $urandom_range(BLOCKS - 1);
      sel   = start;
      if (r < 55) begin
         for (k = BLOCKS - 1; k >= 0; k--) begin
            if (!pool_free[(start + k) % BLOCKS]) sel = (start + k) % BLOCKS;
         end
      end else if (r < 75) begin
         sel = $urandom_range(RESERVED_BLOCKS + 20);
      end
      return IDX_W'(sel);
   endfunction

   // Drive the response ready with random stalls
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Predict on accepted items, check responses, watch for a hang
   always @(posedge clock) begin : monitor
      alloc_outcome_type want;
      logic              moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_if.valid && req_if.ready) begin
            pending_outcomes.push_back(serve_request(req_if.func, req_if.index));
            moved = 1'b1;
         end
         if (csr_if.valid && csr_if.ready) begin
            alloc_on = csr_if.enable;
            moved    = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            if (pending_outcomes.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: granted %0d ok %0d free_left %0d",
                        $time, rsp_if.granted, rsp_if.ok, rsp_if.free_left);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("granted", 32'(want.granted), 32'(rsp_if.granted));
               check_field("ok", 32'(want.ok), 32'(rsp_if.ok));
               check_field("free_left", 32'(want.free_left), 32'(rsp_if.free_left));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, idle_cycles, pending_outcomes.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Send one request item; valid stays high for a back-to-back follower
   task automatic send_request(input logic fn, input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < req_gap_pct) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.func  = fn;
      req_if.index = idx;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and wait for every outstanding response
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      wait_idle();
      @(negedge clock);
      csr_if.valid  = 1'b1;
      csr_if.enable = value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Lowest free blocks come out in order, right after the reserved range on a fresh pool
   task automatic test_first_fit();
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_ALLOC, '1);
      send_request(FUNC_ALLOC, IDX_W'(517));
   endtask

   // Release, double free, reserved blocks and refill of holes
   task automatic test_release();
      send_request(FUNC_FREE, IDX_W'(11));
      send_request(FUNC_FREE, IDX_W'(11));
      send_request(FUNC_FREE, '0);
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_FREE, '1);
      send_request(FUNC_FREE, '0);
      send_request(FUNC_FREE, IDX_W'(RESERVED_BLOCKS - 1));
      send_request(FUNC_ALLOC, '1);
      send_request(FUNC_ALLOC, '0);
   endtask

   // Disabled allocator fails allocations and ignores frees
   task automatic test_disabled();
      write_enable(ALLOC_OFF);
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_FREE, IDX_W'(10));
      send_request(FUNC_FREE, IDX_W'(700));
      send_request(FUNC_FREE, '1);
      write_enable(ALLOC_ON);
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_FREE, IDX_W'(10));
   endtask

   // Mixed allocate and free traffic; idling starts after a quiet stretch
   task automatic test_random_traffic(input int count, input int alloc_pct);
      int i;
      for (i = 0; i < count; i++) begin
         req_gap_pct   = (i < QUIET_ITEMS) ? 0 : IDLE_PCT;
         rsp_stall_pct = req_gap_pct;
         if ($urandom_range(99) < alloc_pct) begin
            send_request(FUNC_ALLOC, IDX_W'($urandom_range(BLOCKS - 1)));
         end else begin
            send_request(FUNC_FREE, pick_block());
         end
      end
   endtask

   // Random requests while the allocator is off
   task automatic test_disabled_traffic(input int count);
      int i;
      write_enable(ALLOC_OFF);
      for (i = 0; i < count; i++) begin
         send_request(logic'($urandom_range(1)), IDX_W'($urandom_range(BLOCKS - 1)));
      end
      write_enable(ALLOC_ON);
   endtask

   initial begin
      int b;
      for (b = 0; b < BLOCKS; b++) pool_free[b] = (b >= RESERVED_BLOCKS);
      pool_count    = FREE_OUT_W'(BLOCKS - RESERVED_BLOCKS);
      alloc_on      = ALLOC_ON;
      errors        = 0;
      idle_cycles   = 0;
      req_gap_pct   = IDLE_PCT;
      rsp_stall_pct = IDLE_PCT;

      // Hold reset with every input at a known value
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.func   = FUNC_ALLOC;
      req_if.index  = '0;
      csr_if.valid  = 1'b0;
      csr_if.enable = ALLOC_ON;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_fit();
      test_release();
      test_disabled();
      test_random_traffic(270, 70);
      test_disabled_traffic(20);
      test_random_traffic(280, 50);
      write_enable(ALLOC_OFF);
      write_enable(ALLOC_ON);
      test_first_fit();
      wait_idle();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
